/* rtl/core/lsb_stego_extract_defines.svh */
// ----------------------------------------------------------------------------
// LSB stego extractor assertion macros
// Shared concurrent assertion forms, clocked on clk and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef LSB_STEGO_EXTRACT_DEFINES_SVH
`define LSB_STEGO_EXTRACT_DEFINES_SVH

// Same-cycle implication
`define LSE_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication
`define LSE_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* rtl/core/lse_pkg.sv */
// ----------------------------------------------------------------------------
// LSB stego extractor package
// Result kinds, parse phases, register codes and fixed widths.
// ----------------------------------------------------------------------------
package lse_pkg;

    localparam int CAP_W        = 31;
    localparam int MAXLEN_W     = 32;
    localparam int CFG_DATA_W   = 32;
    localparam int CFG_INDEX_W  = 2;
    localparam int LEN_OUT_W    = 32;
    localparam int HEADER_BYTES = 4;

    localparam logic [MAXLEN_W-1:0] MAX_LENGTH_RESET = 32'd1000000;

    // Register indexes on the config port
    localparam logic [CFG_INDEX_W-1:0] CFG_CAPACITY   = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_MAX_LENGTH = 2'd1;

    typedef enum logic [1:0] {
        KIND_BYTE    = 2'd0,
        KIND_LENGTH  = 2'd1,
        KIND_NONE    = 2'd2,
        KIND_INVALID = 2'd3
    } result_kind_t;

    typedef enum logic [1:0] {
        PH_IDLE    = 2'd0,
        PH_HEADER  = 2'd1,
        PH_MESSAGE = 2'd2
    } phase_t;

    typedef struct packed {
        result_kind_t         kind;
        logic [7:0]           msg_byte;
        logic [LEN_OUT_W-1:0] length;
        logic                 last;
    } result_t;

endpackage

/* rtl/core/lse_cfg_regs.sv */
// ----------------------------------------------------------------------------
// LSB stego extractor configuration registers
// Capacity and maximum length, written through a plain write port.
// ----------------------------------------------------------------------------
module lse_cfg_regs
(
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_we,
    input  logic [lse_pkg::CFG_INDEX_W-1:0]  cfg_index,
    input  logic [lse_pkg::CFG_DATA_W-1:0]   cfg_data,
    output logic [lse_pkg::CAP_W-1:0]        capacity_bytes,
    output logic [lse_pkg::MAXLEN_W-1:0]     max_length
);
    import lse_pkg::*;

    logic [CAP_W-1:0]    capacity_reg;
    logic [MAXLEN_W-1:0] max_length_reg;

    // Register write decode; unknown indexes are dropped
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            capacity_reg   <= '0;
            max_length_reg <= MAX_LENGTH_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_CAPACITY:   capacity_reg   <= cfg_data[CAP_W-1:0];
                CFG_MAX_LENGTH: max_length_reg <= cfg_data[MAXLEN_W-1:0];
                default:        ;
            endcase
        end
    end

    assign capacity_bytes = capacity_reg;
    assign max_length     = max_length_reg;

endmodule

/* rtl/core/lse_parser.sv */
// ----------------------------------------------------------------------------
// LSB stego extractor parser
// Shifts in hidden bits, checks the length header and assembles bytes.
// ----------------------------------------------------------------------------
`include "lsb_stego_extract_defines.svh"

module lse_parser
#(
    parameter int LENGTH_BITS = 32
)
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          step,
    input  logic                          hidden_bit,
    input  logic                          frame_start,
    input  logic [lse_pkg::CAP_W-1:0]     capacity_bytes,
    input  logic [lse_pkg::MAXLEN_W-1:0]  max_length,
    output logic                          res_valid,
    output lse_pkg::result_t              res
);
    import lse_pkg::*;

    localparam int CNT_W = (LENGTH_BITS > 8) ? $clog2(LENGTH_BITS) : 3;
    localparam logic [CNT_W-1:0] HDR_LAST = CNT_W'(LENGTH_BITS - 1);
    localparam logic [CNT_W-1:0] BYTE_LAST = CNT_W'(7);

    phase_t                 phase_reg, phase_next;
    logic [LENGTH_BITS-1:0] len_reg, len_next;
    logic [CNT_W-1:0]       cnt_reg, cnt_next;
    logic [7:0]             byte_reg, byte_next;
    logic [LENGTH_BITS-1:0] left_reg, left_next;

    phase_t                 phase_cur;
    logic [LENGTH_BITS-1:0] len_cur, len_shifted, left_cur;
    logic [CNT_W-1:0]       cnt_cur;
    logic [7:0]             byte_cur, byte_shifted;
    logic                   too_big, over_cap, is_last;

    // State registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_IDLE;
            len_reg   <= '0;
            cnt_reg   <= '0;
            byte_reg  <= '0;
            left_reg  <= '0;
        end
        else if (step)
        begin
            phase_reg <= phase_next;
            len_reg   <= len_next;
            cnt_reg   <= cnt_next;
            byte_reg  <= byte_next;
            left_reg  <= left_next;
        end
    end

    // Frame start drops any parse in progress
    always_comb
    begin
        phase_cur = frame_start ? PH_HEADER : phase_reg;
        len_cur   = frame_start ? '0 : len_reg;
        cnt_cur   = frame_start ? '0 : cnt_reg;
        byte_cur  = frame_start ? '0 : byte_reg;
        left_cur  = frame_start ? '0 : left_reg;
    end

    assign len_shifted  = {len_cur[LENGTH_BITS-2:0], hidden_bit};
    assign byte_shifted = {byte_cur[6:0], hidden_bit};
    assign too_big      = 32'(len_shifted) > max_length;
    assign over_cap     = (33'(len_shifted) + 33'(HEADER_BYTES)) > 33'(capacity_bytes);
    assign is_last      = (left_cur <= LENGTH_BITS'(1));

    // Next state and result
    always_comb
    begin
        phase_next = phase_cur;
        len_next   = len_cur;
        cnt_next   = cnt_cur;
        byte_next  = byte_cur;
        left_next  = left_cur;
        res_valid  = 1'b0;
        res        = '{kind: KIND_BYTE, msg_byte: '0, length: '0, last: 1'b0};

        unique case (phase_cur)
            PH_HEADER:
            begin
                len_next = len_shifted;
                if (cnt_cur != HDR_LAST)
                begin
                    cnt_next = cnt_cur + 1'b1;
                end
                else
                begin
                    cnt_next   = '0;
                    res_valid  = 1'b1;
                    res.length = LEN_OUT_W'(len_shifted);
                    if (len_shifted == '0)
                    begin
                        phase_next = PH_IDLE;
                        res.kind   = KIND_NONE;
                        res.last   = 1'b1;
                    end
                    else if (too_big || over_cap)
                    begin
                        phase_next = PH_IDLE;
                        res.kind   = KIND_INVALID;
                        res.last   = 1'b1;
                    end
                    else
                    begin
                        phase_next = PH_MESSAGE;
                        left_next  = len_shifted;
                        byte_next  = '0;
                        res.kind   = KIND_LENGTH;
                    end
                end
            end
            PH_MESSAGE:
            begin
                byte_next = byte_shifted;
                if (cnt_cur != BYTE_LAST)
                begin
                    cnt_next = cnt_cur + 1'b1;
                end
                else
                begin
                    res_valid    = 1'b1;
                    res.kind     = KIND_BYTE;
                    res.msg_byte = byte_shifted;
                    res.last     = is_last;
                    cnt_next     = '0;
                    byte_next    = '0;
                    if (left_cur != '0)
                        left_next = left_cur - 1'b1;
                    if (is_last)
                        phase_next = PH_IDLE;
                end
            end
            PH_IDLE:
            begin
            end
            default:
            begin
            end
        endcase
    end

    // Checks
    `LSE_ASSERT_SAME(a_byte_from_message,
        step && res_valid && (res.kind == KIND_BYTE),
        (phase_reg == PH_MESSAGE) && !frame_start,
        "message byte produced outside message phase")
    `LSE_ASSERT_SAME(a_last_on_header_result,
        step && res_valid && (res.kind != KIND_BYTE),
        res.last == (res.kind != KIND_LENGTH),
        "last flag wrong on header result")
    `LSE_ASSERT_NEXT(a_idle_after_last,
        step && res_valid && res.last,
        phase_reg == PH_IDLE,
        "parser not idle after final result")
    `LSE_ASSERT_NEXT(a_message_after_length,
        step && res_valid && (res.kind == KIND_LENGTH),
        (phase_reg == PH_MESSAGE) && (cnt_reg == '0) && (left_reg != '0),
        "message phase not entered cleanly after length")

endmodule

/* rtl/core/lsb_stego_extract.sv */
// The input register holds an accepted pixel bit, the result register its result.
// Throughput: one pixel byte per cycle while out_stall does not hold the output;
// each register takes a new transaction whenever the stage ahead moves.
// Reset (rst_n low, asynchronous): parser idle, waiting for a frame start;
// capacity_bytes = 0, max_length = 1000000; both channels empty.
// ----------------------------------------------------------------------------
// LSB stego extractor
// Recovers a length-prefixed message from the low bits of pixel bytes.
// ----------------------------------------------------------------------------
module lsb_stego_extract
#(
    parameter int LENGTH_BITS = 32
)
(
    input  logic                             clk,
    input  logic                             rst_n,
    // Input channel
    input  logic                             in_valid,
    output logic                             in_stall,
    input  logic [7:0]                       pixel_byte,
    input  logic                             frame_start,
    // Output channel
    output logic                             out_valid,
    input  logic                             out_stall,
    output logic [1:0]                       result_kind,
    output logic [7:0]                       message_byte,
    output logic [lse_pkg::LEN_OUT_W-1:0]    length_value,
    output logic                             last,
    // Configuration
    input  logic                             cfg_we,
    input  logic [lse_pkg::CFG_INDEX_W-1:0]  cfg_index,
    input  logic [lse_pkg::CFG_DATA_W-1:0]   cfg_data
);
    import lse_pkg::*;

    logic                in_valid_reg;
    logic                in_bit_reg;
    logic                in_fs_reg;
    logic                out_valid_reg;
    result_t             out_res_reg;
    logic                advance;
    logic                step;
    logic                res_valid;
    result_t             res;
    logic [CAP_W-1:0]    capacity_bytes;
    logic [MAXLEN_W-1:0] max_length;

    lse_cfg_regs u_cfg
    (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_we         (cfg_we),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .capacity_bytes (capacity_bytes),
        .max_length     (max_length)
    );

    lse_parser #(.LENGTH_BITS(LENGTH_BITS)) u_parser
    (
        .clk            (clk),
        .rst_n          (rst_n),
        .step           (step),
        .hidden_bit     (in_bit_reg),
        .frame_start    (in_fs_reg),
        .capacity_bytes (capacity_bytes),
        .max_length     (max_length),
        .res_valid      (res_valid),
        .res            (res)
    );

    // Pipeline flow control
    assign advance  = !out_valid_reg || !out_stall;
    assign step     = in_valid_reg && advance;
    assign in_stall = in_valid_reg && !advance;

    // Input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else if (!in_stall)
            in_valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && !in_stall)
        begin
            in_bit_reg <= pixel_byte[0];
            in_fs_reg  <= frame_start;
        end
    end

    // Result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (advance)
            out_valid_reg <= step && res_valid;
    end

    always_ff @(posedge clk)
    begin
        if (step && res_valid)
            out_res_reg <= res;
    end

    assign out_valid    = out_valid_reg;
    assign result_kind  = out_res_reg.kind;
    assign message_byte = out_res_reg.msg_byte;
    assign length_value = out_res_reg.length;
    assign last         = out_res_reg.last;

endmodule
